[sv/assert_macros.svh]
// Assertion macros shared by the evaluator RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define RSE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RSE_ASSERT(lbl, clk, rstn, prop, msg)
`define RSE_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/rse_pkg.sv]
// Package of the RPN stack evaluator: field widths, opcodes, status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package rse_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned OPC_W       = 5;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned DEPTH_OUT_W = 5;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_CONST  = 5'd0,
    OP_PUSH_SAMPLE = 5'd1,
    OP_WRITE_SAMPLE = 5'd2,
    OP_LNOT        = 5'd3,
    OP_BNOT        = 5'd4,
    OP_MUL         = 5'd5,
    OP_DIV         = 5'd6,
    OP_MOD         = 5'd7,
    OP_ADD         = 5'd8,
    OP_SUB         = 5'd9,
    OP_SHL         = 5'd10,
    OP_SHR         = 5'd11,
    OP_AND         = 5'd12,
    OP_OR          = 5'd13,
    OP_XOR         = 5'd14,
    OP_GT          = 5'd15,
    OP_LT          = 5'd16,
    OP_GE          = 5'd17,
    OP_LE          = 5'd18,
    OP_EQ          = 5'd19,
    OP_NE          = 5'd20,
    OP_LAND        = 5'd21,
    OP_LOR         = 5'd22,
    OP_POP_COND    = 5'd23,
    OP_CLEAR       = 5'd24
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIVW,
    S_DONE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch input word, read stack and sample table
    logic div_start;  // launch the divider
    logic commit;     // update stack/samples, register the result
    logic out_load;   // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;   // current word is a divide/modulo with nonzero divisor
    logic div_done;   // divider finished
  } sts_t;

endpackage

`default_nettype wire

[sv/rse_in_if.sv]
// Input channel of the evaluator: valid/ready plus one instruction word.
// Depends on rse_pkg for field widths.
`default_nettype none

interface rse_in_if import rse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         operation;
  logic signed [DATA_W-1:0] operand;
  logic [IDX_W-1:0]         sample_index;

  modport source (output valid, output operation, output operand,
                  output sample_index, input ready);
  modport sink   (input valid, input operation, input operand,
                  input sample_index, output ready);
endinterface

`default_nettype wire

[sv/rse_out_if.sv]
// Result channel of the evaluator: valid/ready plus one result word.
// Depends on rse_pkg for field widths.
`default_nettype none

interface rse_out_if import rse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_OUT_W-1:0]   depth;
  logic                     condition_valid;
  logic                     condition_true;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output top_value, output depth,
                  output condition_valid, output condition_true,
                  output status, input ready);
  modport sink   (input valid, input top_value, input depth,
                  input condition_valid, input condition_true,
                  input status, output ready);
endinterface

`default_nettype wire

[sv/rse_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on rse_pkg for DATA_W and DIV_STEPS.
`default_nettype none

module rse_div import rse_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic [DATA_W-1:0]      quotient_o,
  output logic [DATA_W-1:0]      remainder_o,
  output logic                   done_o
);

  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;

  // one shift-subtract step
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

[sv/rse_datapath.sv]
// Datapath of the evaluator: value stack and sample table memories, ALU,
// divider, depth counter and the result/output registers.
// Depends on rse_pkg and rse_div.
`default_nettype none

module rse_datapath import rse_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = 16,
  parameter int unsigned SAMPLE_COUNT = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [OPC_W-1:0]         operation_i,
  input  wire logic signed [DATA_W-1:0] operand_i,
  input  wire logic [IDX_W-1:0]         sample_index_i,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  output logic signed [DATA_W-1:0]      top_value_o,
  output logic [DEPTH_OUT_W-1:0]        depth_o,
  output logic                          condition_valid_o,
  output logic                          condition_true_o,
  output logic [STAT_W-1:0]             status_o
);

  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SIW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int unsigned IXW = ((SIW > IDX_W) ? SIW : IDX_W) + 1;
  localparam int unsigned OXW = (DW > DEPTH_OUT_W) ? DW : DEPTH_OUT_W;

  // memories
  logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] smp_mem   [SAMPLE_COUNT];
  logic [SAMPLE_COUNT-1:0]  smp_vld_q;

  // captured word and read data
  op_e                      op_q;
  logic signed [DATA_W-1:0] operand_q;
  logic [SIW-1:0]           saddr_q;
  logic                     in_range_q;
  logic signed [DATA_W-1:0] top_rd_q, next_rd_q, smp_rd_q;
  logic                     smp_ok_q;

  logic [DW-1:0] depth_q, depth_d, depth_nxt;
  logic [DW-1:0] dm1, dm2;

  // result and output registers
  logic signed [DATA_W-1:0] res_top_q, out_top_q;
  logic [DW-1:0]            res_depth_q, out_depth_q;
  logic                     res_cv_q, res_ct_q, out_cv_q, out_ct_q;
  status_e                  res_st_q, out_st_q;

  // sample index decode on the incoming word
  logic [IXW-1:0] idx_ext;
  logic [SIW-1:0] saddr_in;
  logic           in_range_in;

  assign idx_ext     = IXW'(sample_index_i);
  assign saddr_in    = idx_ext[SIW-1:0];
  assign in_range_in = idx_ext < IXW'(SAMPLE_COUNT);

  assign dm1 = depth_q - DW'(1);
  assign dm2 = depth_q - DW'(2);

  // capture the word and read top, next-to-top and the sample
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_e'(operation_i);
      operand_q  <= operand_i;
      saddr_q    <= saddr_in;
      in_range_q <= in_range_in;
      top_rd_q   <= stack_mem[dm1[AW-1:0]];
      next_rd_q  <= stack_mem[dm2[AW-1:0]];
      smp_rd_q   <= smp_mem[saddr_in];
      smp_ok_q   <= in_range_in && smp_vld_q[saddr_in];
    end
  end

  // operand view
  logic signed [DATA_W-1:0]   a, b, smp_val;
  logic                       has1, has2, full, b_zero;
  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]          a_abs, b_abs, quo, rem;
  logic signed [DATA_W-1:0]   div_res, bin_res;
  logic                       big_shift;
  logic [3:0]                 sh;
  logic                       need_div, div_done;

  assign a       = next_rd_q;
  assign b       = top_rd_q;
  assign smp_val = smp_ok_q ? smp_rd_q : '0;
  assign has1    = depth_q != '0;
  assign has2    = depth_q >= DW'(2);
  assign full    = depth_q == DW'(STACK_DEPTH);
  assign b_zero  = b == '0;
  assign prod    = a * b;
  assign sh        = b[3:0];
  assign big_shift = |b[DATA_W-1:4];

  // divider on magnitudes, signs fixed up afterwards
  assign a_abs = a[DATA_W-1] ? DATA_W'(-a) : a;
  assign b_abs = b[DATA_W-1] ? DATA_W'(-b) : b;

  rse_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (a_abs),
    .divisor_i   (b_abs),
    .quotient_o  (quo),
    .remainder_o (rem),
    .done_o      (div_done)
  );

  always_comb begin
    if (op_q == OP_DIV) begin
      div_res = (a[DATA_W-1] ^ b[DATA_W-1]) ? DATA_W'(-quo) : quo;
    end else begin
      div_res = a[DATA_W-1] ? DATA_W'(-rem) : rem;
    end
  end

  assign need_div = ((op_q == OP_DIV) || (op_q == OP_MOD)) && has2 && !b_zero;
  assign sts_o    = '{need_div: need_div, div_done: div_done};

  // binary operator result
  always_comb begin
    case (op_q)
      OP_MUL:  bin_res = prod[DATA_W-1:0];
      OP_DIV,
      OP_MOD:  bin_res = b_zero ? '0 : div_res;
      OP_ADD:  bin_res = a + b;
      OP_SUB:  bin_res = a - b;
      OP_SHL:  bin_res = big_shift ? '0 : a << sh;
      // both arms signed so the shift keeps the sign
      OP_SHR:  bin_res = big_shift ? $signed({DATA_W{a[DATA_W-1]}}) : a >>> sh;
      OP_AND:  bin_res = a & b;
      OP_OR:   bin_res = a | b;
      OP_XOR:  bin_res = a ^ b;
      OP_GT:   bin_res = DATA_W'(a > b);
      OP_LT:   bin_res = DATA_W'(a < b);
      OP_GE:   bin_res = DATA_W'(a >= b);
      OP_LE:   bin_res = DATA_W'(a <= b);
      OP_EQ:   bin_res = DATA_W'(a == b);
      OP_NE:   bin_res = DATA_W'(a != b);
      OP_LAND: bin_res = DATA_W'((a != '0) && (b != '0));
      OP_LOR:  bin_res = DATA_W'((a != '0) || (b != '0));
      default: bin_res = '0;
    endcase
  end

  // effect of the word on stack, samples and the result
  logic                     stk_we, smp_we;
  logic [AW-1:0]            stk_addr;
  logic signed [DATA_W-1:0] stk_wdata, new_top, push_val;
  logic                     cv, ct;
  status_e                  st;

  assign push_val = (op_q == OP_PUSH_SAMPLE) ? smp_val : operand_q;

  always_comb begin
    stk_we    = 1'b0;
    smp_we    = 1'b0;
    stk_addr  = dm1[AW-1:0];
    stk_wdata = bin_res;
    depth_nxt = depth_q;
    new_top   = has1 ? b : '0;
    cv        = 1'b0;
    ct        = 1'b0;
    st        = ST_OK;
    case (op_q)
      OP_PUSH_CONST, OP_PUSH_SAMPLE: begin
        if (full) begin
          st = ST_OVER;
        end else begin
          stk_we    = 1'b1;
          stk_addr  = depth_q[AW-1:0];
          stk_wdata = push_val;
          depth_nxt = depth_q + DW'(1);
          new_top   = push_val;
        end
      end
      OP_WRITE_SAMPLE: begin
        smp_we = in_range_q;
      end
      OP_LNOT, OP_BNOT: begin
        if (!has1) begin
          st = ST_UNDER;
        end else begin
          stk_we    = 1'b1;
          stk_wdata = (op_q == OP_LNOT) ? DATA_W'(b_zero) : ~b;
          new_top   = stk_wdata;
        end
      end
      OP_MUL, OP_DIV, OP_MOD, OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_AND,
      OP_OR, OP_XOR, OP_GT, OP_LT, OP_GE, OP_LE, OP_EQ, OP_NE,
      OP_LAND, OP_LOR: begin
        if (!has2) begin
          st = ST_UNDER;
        end else begin
          stk_we    = 1'b1;
          stk_addr  = dm2[AW-1:0];
          stk_wdata = bin_res;
          depth_nxt = dm1;
          new_top   = bin_res;
          if (((op_q == OP_DIV) || (op_q == OP_MOD)) && b_zero) begin
            st = ST_DIVZERO;
          end
        end
      end
      OP_POP_COND: begin
        if (!has1) begin
          st = ST_UNDER;
        end else begin
          depth_nxt = dm1;
          cv        = 1'b1;
          ct        = !b_zero;
          new_top   = has2 ? a : '0;
        end
      end
      OP_CLEAR: begin
        depth_nxt = '0;
        new_top   = '0;
      end
      default: begin
      end
    endcase
  end

  assign depth_d = cmd_i.commit ? depth_nxt : depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // stack write
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && stk_we) begin
      stack_mem[stk_addr] <= stk_wdata;
    end
  end

  // sample table write; valid bits make unwritten entries read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && smp_we) begin
      smp_mem[saddr_q] <= operand_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= '0;
    end else if (cmd_i.commit && smp_we) begin
      smp_vld_q[saddr_q] <= 1'b1;
    end
  end

  // result register, then output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_top_q   <= new_top;
      res_depth_q <= depth_nxt;
      res_cv_q    <= cv;
      res_ct_q    <= ct;
      res_st_q    <= st;
    end
    if (cmd_i.out_load) begin
      out_top_q   <= res_top_q;
      out_depth_q <= res_depth_q;
      out_cv_q    <= res_cv_q;
      out_ct_q    <= res_ct_q;
      out_st_q    <= res_st_q;
    end
  end

  logic [OXW-1:0] depth_ext;

  assign depth_ext         = OXW'(out_depth_q);
  assign top_value_o       = out_top_q;
  assign depth_o           = depth_ext[DEPTH_OUT_W-1:0];
  assign condition_valid_o = out_cv_q;
  assign condition_true_o  = out_ct_q;
  assign status_o          = out_st_q;

endmodule

`default_nettype wire

[sv/rse_ctrl.sv]
// Controller of the evaluator: sequences capture, execute, divide wait and
// result hand-off. Depends on rse_pkg.
`default_nettype none

module rse_ctrl import rse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVW;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/rpn_stack_evaluator_top.sv]
// Top level of the RPN stack evaluator: controller plus datapath.
// Depends on rse_pkg, rse_in_if, rse_out_if, rse_ctrl, rse_datapath and
// assert_macros.svh.
//
// Usage: each word on in_i is one postfix instruction (operation, operand,
// sample_index); each accepted word yields exactly one word on out_o with
// the top of stack, the depth, the popped condition and a status code.
// Sequence: a word is taken in the idle state, executed in the next cycle and
// loaded into the output register from S_DONE, after which out_o.valid rises;
// the next word is taken only once the controller is back in S_IDLE.
// Divide and modulo with two operands and a nonzero divisor run the shared
// radix-2 divider for its 16 steps before the result is committed.
// The output register decouples the sides: a new word is accepted while a
// finished result waits; if the receiver keeps out_o.ready low, the next
// result stays in the datapath and the block stops accepting until the
// output register is taken.
// Reset clears the stack depth, the sample table valid bits (all samples
// read as zero) and the handshake state; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module rpn_stack_evaluator_top import rse_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = 16,
  parameter int unsigned SAMPLE_COUNT = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rse_in_if.sink    in_i,
  rse_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  rse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rse_datapath #(
    .STACK_DEPTH  (STACK_DEPTH),
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (in_i.operation),
    .operand_i         (in_i.operand),
    .sample_index_i    (in_i.sample_index),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .top_value_o       (out_o.top_value),
    .depth_o           (out_o.depth),
    .condition_valid_o (out_o.condition_valid),
    .condition_true_o  (out_o.condition_true),
    .status_o          (out_o.status)
  );

  // checks
  `RSE_NEVER(a_cap_commit, clk_i, rst_ni, cmd.capture && cmd.commit, "capture during commit")
  `RSE_ASSERT(a_one_word, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> !in_i.ready, "second word taken while busy")
  `RSE_ASSERT(a_div_lat, clk_i, rst_ni, cmd.div_start |=> !sts.div_done, "divider done too early")
  `RSE_ASSERT(a_divz_top, clk_i, rst_ni, (out_o.valid && (out_o.status == ST_DIVZERO)) |-> (out_o.top_value == '0), "divide by zero top not zero")

endmodule

`default_nettype wire
